[hdl/matrix_add_sub_mul_engine_unit_defines.svh]
// ----------------------------------------------------------------------------
// matrix engine assertion macros
// shared property forms for the checker of the matrix engine
// ----------------------------------------------------------------------------
`ifndef MATRIX_ADD_SUB_MUL_ENGINE_UNIT_DEFINES_SVH
`define MATRIX_ADD_SUB_MUL_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define MASE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matrix engine check failed");

// next-cycle implication, off during reset
`define MASE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matrix engine check failed");

// next-cycle implication that also holds across reset
`define MASE_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("matrix engine check failed");

`endif

[hdl/mase_pkg.sv]
// ----------------------------------------------------------------------------
// matrix engine package
// shared constants, codes, types and helper functions
// ----------------------------------------------------------------------------
package mase_pkg;

  localparam int MAX_DIM     = 8;
  localparam int ELEM_BITS   = 16;
  localparam int DEPTH       = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(MAX_DIM + 1);
  localparam int DIM_W       = 4;
  localparam int MODE_W      = 2;
  localparam int ACT_W       = 2;
  localparam int VALUE_W     = 16;
  localparam int RES_W       = 35;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [RES_W-1:0] ERR_VALUE = RES_W'(9999);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 3'd4;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_COMPUTE
  } cmd_t;

  typedef struct packed {
    cmd_t                  kind;
    logic [ADDR_W-1:0]     addr;
    logic [ELEM_BITS-1:0]  data;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  rows_a;
    logic [CNT_W-1:0]  cols_a;
    logic [CNT_W-1:0]  rows_b;
    logic [CNT_W-1:0]  cols_b;
  } cfg_t;

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [CNT_W-1:0] r;
    if (d == '0) begin
      r = CNT_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(d);
    end
    return r;
  endfunction

  function automatic logic [ELEM_BITS-1:0] to_elem(input logic signed [VALUE_W-1:0] v);
    logic signed [ELEM_BITS-1:0] r;
    r = ELEM_BITS'(v);
    return r;
  endfunction

endpackage

[hdl/matrix_add_sub_mul_engine_unit.sv]
// the back end writes each load item into its store as it pops it; a compute item runs
// one result at a time through the read, product and accumulate steps, over the single
// multiplier and one read port per store, and no queued item is taken until the run ends.
// the front takes a new word every cycle while the four-entry command queue has room.
// reset clears control state, the load pointers and config (mode multiply, all dims 1);
// the element stores are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
// matrix add, subtract and multiply engine
// loads two matrices element by element and streams out sum, difference or product
// ----------------------------------------------------------------------------
module matrix_add_sub_mul_engine_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mase_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mase_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mase_pkg::ACT_W-1:0]           action,
  input  logic signed [mase_pkg::VALUE_W-1:0]  value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mase_pkg::RES_W-1:0]    result_value,
  output logic                                 dim_error,
  output logic                                 last
);
  import mase_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_empty;
  logic  pop;
  item_t head;
  cfg_t  cfg;

  mase_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .value     (value),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  mase_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  mase_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .dim_error    (dim_error),
    .last         (last)
  );

endmodule

[hdl/mase_ram.sv]
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mase_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/mase_front.sv]
// ----------------------------------------------------------------------------
// matrix engine front
// config registers, input decode and load address generation
// ----------------------------------------------------------------------------
module mase_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mase_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mase_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mase_pkg::ACT_W-1:0]        action,
  input  logic signed [mase_pkg::VALUE_W-1:0] value,
  input  logic                              q_full,
  output logic                              push,
  output mase_pkg::item_t                   push_item,
  output mase_pkg::cfg_t                    cfg
);
  import mase_pkg::*;

  logic [MODE_W-1:0] mode;
  logic [DIM_W-1:0]  rows_a;
  logic [DIM_W-1:0]  cols_a;
  logic [DIM_W-1:0]  rows_b;
  logic [DIM_W-1:0]  cols_b;
  logic [ADDR_W-1:0] ptr_a;
  logic [ADDR_W-1:0] ptr_b;
  logic              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (action != ACT_NONE);

  always_comb begin
    push_item.data = to_elem(value);
    push_item.addr = '0;
    push_item.kind = CMD_COMPUTE;
    unique case (action)
      ACT_LOAD_A: begin
        push_item.kind = CMD_LOAD_A;
        push_item.addr = ptr_a;
      end
      ACT_LOAD_B: begin
        push_item.kind = CMD_LOAD_B;
        push_item.addr = ptr_b;
      end
      default: begin
        push_item.kind = CMD_COMPUTE;
      end
    endcase
  end

  assign cfg.mode   = mode;
  assign cfg.rows_a = clamp_dim(rows_a);
  assign cfg.cols_a = clamp_dim(cols_a);
  assign cfg.rows_b = clamp_dim(rows_b);
  assign cfg.cols_b = clamp_dim(cols_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_MUL;
      rows_a <= DIM_W'(1);
      cols_a <= DIM_W'(1);
      rows_b <= DIM_W'(1);
      cols_b <= DIM_W'(1);
      ptr_a  <= '0;
      ptr_b  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:   mode   <= cfg_data[MODE_W-1:0];
          REG_ROWS_A: rows_a <= cfg_data;
          REG_COLS_A: cols_a <= cfg_data;
          REG_ROWS_B: rows_b <= cfg_data;
          REG_COLS_B: cols_b <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        unique case (action)
          ACT_LOAD_A: begin
            ptr_a <= (32'(ptr_a) == DEPTH - 1) ? '0 : ptr_a + ADDR_W'(1);
          end
          ACT_LOAD_B: begin
            ptr_b <= (32'(ptr_b) == DEPTH - 1) ? '0 : ptr_b + ADDR_W'(1);
          end
          ACT_COMPUTE: begin
            ptr_a <= '0;
            ptr_b <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[hdl/mase_queue.sv]
// ----------------------------------------------------------------------------
// matrix engine command queue
// small fifo of decoded words between front and back
// ----------------------------------------------------------------------------
module mase_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mase_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output mase_pkg::item_t head
);
  import mase_pkg::*;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (32'(count) == QUEUE_DEPTH);
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

endmodule

[hdl/mase_back.sv]
// ----------------------------------------------------------------------------
// matrix engine back
// executes queued loads and walks compute runs over one shared multiplier
// ----------------------------------------------------------------------------
module mase_back (
  input  logic                                clk,
  input  logic                                rst,
  input  mase_pkg::cfg_t                      cfg,
  input  logic                                q_empty,
  input  mase_pkg::item_t                     head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mase_pkg::RES_W-1:0]   result_value,
  output logic                                dim_error,
  output logic                                last
);
  import mase_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            i;
  logic [CNT_W-1:0]            j;
  logic [CNT_W-1:0]            z;
  logic [ADDR_W-1:0]           row_a;
  logic [ADDR_W-1:0]           row_b;
  logic [ADDR_W-1:0]           cur_a;
  logic [ADDR_W-1:0]           cur_b;
  logic                        err;
  logic                        p1;
  logic                        p2;
  logic signed [RES_W-1:0]     prod;
  logic signed [RES_W-1:0]     acc;

  logic [ELEM_BITS-1:0]        rd_a;
  logic [ELEM_BITS-1:0]        rd_b;
  logic                        we_a;
  logic                        we_b;
  logic                        is_mul;
  logic                        is_sub;
  logic [CNT_W-1:0]            terms;
  logic [CNT_W-1:0]            cols;
  logic [CNT_W-1:0]            j_inc;
  logic                        row_end;
  logic                        is_last;
  logic                        out_free;
  logic [ADDR_W-1:0]           row_a_next;
  logic [ADDR_W-1:0]           row_b_next;
  logic signed [2*ELEM_BITS-1:0] mul_full;
  logic signed [ELEM_BITS:0]     sum_full;

  assign pop  = (state == ST_IDLE) && !q_empty;
  assign we_a = pop && (head.kind == CMD_LOAD_A);
  assign we_b = pop && (head.kind == CMD_LOAD_B);

  mase_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (head.addr),
    .wdata (head.data),
    .raddr (cur_a),
    .rdata (rd_a)
  );

  mase_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (head.addr),
    .wdata (head.data),
    .raddr (cur_b),
    .rdata (rd_b)
  );

  // mode 3 runs as multiply
  assign is_mul   = cfg.mode[1];
  assign is_sub   = (cfg.mode == MODE_SUB);
  assign terms    = is_mul ? cfg.cols_a : CNT_W'(1);
  assign cols     = is_mul ? cfg.cols_b : cfg.cols_a;
  assign j_inc    = j + CNT_W'(1);
  assign row_end  = (j == cols - CNT_W'(1));
  assign is_last  = err || (row_end && (i == cfg.rows_a - CNT_W'(1)));
  assign out_free = !out_valid || !out_stall;

  assign row_a_next = row_a + ADDR_W'(cfg.cols_a);
  assign row_b_next = row_b + ADDR_W'(cfg.cols_b);

  always_comb begin
    mul_full = $signed(rd_a) * $signed(rd_b);
    if (is_sub) begin
      sum_full = $signed({rd_a[ELEM_BITS-1], rd_a}) - $signed({rd_b[ELEM_BITS-1], rd_b});
    end else begin
      sum_full = $signed({rd_a[ELEM_BITS-1], rd_a}) + $signed({rd_b[ELEM_BITS-1], rd_b});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      p1        <= 1'b0;
      p2        <= 1'b0;
      acc       <= '0;
      err       <= 1'b0;
      i         <= '0;
      j         <= '0;
      z         <= '0;
      row_a     <= '0;
      row_b     <= '0;
      cur_a     <= '0;
      cur_b     <= '0;
    end else begin
      // read, product, accumulate
      p1 <= (state == ST_RUN);
      p2 <= p1;
      if (p1) begin
        prod <= is_mul ? RES_W'(mul_full) : RES_W'(sum_full);
      end
      if (p2) begin
        acc <= acc + prod;
      end

      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (!q_empty && head.kind == CMD_COMPUTE) begin
            i     <= '0;
            j     <= '0;
            z     <= '0;
            row_a <= '0;
            row_b <= '0;
            cur_a <= '0;
            cur_b <= '0;
            if (is_mul && cfg.cols_a != cfg.rows_b) begin
              err   <= 1'b1;
              state <= ST_EMIT;
            end else begin
              err   <= 1'b0;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (z == terms - CNT_W'(1)) begin
            state <= ST_DRAIN;
          end else begin
            z     <= z + CNT_W'(1);
            cur_a <= cur_a + ADDR_W'(1);
            cur_b <= cur_b + ADDR_W'(cfg.cols_b);
          end
        end
        ST_DRAIN: begin
          if (!p1 && !p2) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            result_value <= err ? ERR_VALUE : acc;
            dim_error    <= err;
            last         <= is_last;
            acc          <= '0;
            z            <= '0;
            if (is_last) begin
              err   <= 1'b0;
              state <= ST_IDLE;
            end else if (row_end) begin
              // next row, first column
              i     <= i + CNT_W'(1);
              j     <= '0;
              row_a <= row_a_next;
              row_b <= row_b_next;
              cur_a <= row_a_next;
              cur_b <= is_mul ? '0 : row_b_next;
              state <= ST_RUN;
            end else begin
              j     <= j_inc;
              cur_a <= is_mul ? row_a : row_a + ADDR_W'(j_inc);
              cur_b <= is_mul ? ADDR_W'(j_inc) : row_b + ADDR_W'(j_inc);
              state <= ST_RUN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/matrix_add_sub_mul_engine_unit_checker.sv]
// ----------------------------------------------------------------------------
// matrix engine checker
// port-level properties of the matrix engine, bound to the top level
// ----------------------------------------------------------------------------
`include "matrix_add_sub_mul_engine_unit_defines.svh"

module matrix_add_sub_mul_engine_unit_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [mase_pkg::RES_W-1:0]    result_value,
  input logic                                 dim_error,
  input logic                                 last
);
  import mase_pkg::*;

  logic [RES_W+1:0] out_word;

  assign out_word = {result_value, dim_error, last};

  // a stalled word stays up
  `MASE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // a stalled word keeps its payload
  `MASE_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_word))

  // a dimension error is a lone word carrying the error value
  `MASE_ASSERT_SAME(a_err_word, clk, rst, out_valid && dim_error, last && (result_value == ERR_VALUE))

  // reset empties the output register
  `MASE_ASSERT_ALWAYS(a_rst_clear, clk, rst, !out_valid)

endmodule

bind matrix_add_sub_mul_engine_unit matrix_add_sub_mul_engine_unit_checker u_checker (.*);
